@@ sv/uuidp_pkg.sv @@
package uuidp_pkg;

  // Character codes the parser recognizes
  localparam logic [7:0] ChNul    = 8'h00;
  localparam logic [7:0] ChDash   = 8'h2D;
  localparam logic [7:0] ChLBrace = 8'h7B;
  localparam logic [7:0] ChRBrace = 8'h7D;

  // Body: 32 hex digits and 4 dashes, grouped 8-4-4-4-12
  localparam int unsigned BodyLen = 36;
  localparam int unsigned IdxW    = 6;
  localparam logic [IdxW-1:0] DashPos0 = IdxW'(8);
  localparam logic [IdxW-1:0] DashPos1 = IdxW'(13);
  localparam logic [IdxW-1:0] DashPos2 = IdxW'(18);
  localparam logic [IdxW-1:0] DashPos3 = IdxW'(23);
  localparam logic [IdxW-1:0] BodyLast = IdxW'(BodyLen - 1);

  // Default depth of the token queue between front and back
  localparam int unsigned QDepthDefault = 4;

  localparam int unsigned HalfW = 64;

  typedef enum logic [2:0] {
    TK_NUL    = 3'd0,
    TK_LBRACE = 3'd1,
    TK_RBRACE = 3'd2,
    TK_DASH   = 3'd3,
    TK_HEX    = 3'd4,
    TK_OTHER  = 3'd5
  } tok_kind_e;

  typedef struct packed {
    tok_kind_e  kind;
    logic [3:0] nibble;
  } tok_t;

endpackage

@@ sv/uuidp_front.sv @@
module uuidp_front
  import uuidp_pkg::*;
(
  input  logic [7:0] ch_i,
  output tok_t       tok_o
);

  // Classify one character into a token, decoding hex digits on the way
  always_comb begin
    tok_o.kind   = TK_OTHER;
    tok_o.nibble = 4'd0;
    if (ch_i == ChNul) begin
      tok_o.kind = TK_NUL;
    end else if (ch_i == ChLBrace) begin
      tok_o.kind = TK_LBRACE;
    end else if (ch_i == ChRBrace) begin
      tok_o.kind = TK_RBRACE;
    end else if (ch_i == ChDash) begin
      tok_o.kind = TK_DASH;
    end else if (ch_i inside {[8'h30:8'h39]}) begin
      tok_o.kind   = TK_HEX;
      tok_o.nibble = ch_i[3:0];
    end else if (ch_i inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      tok_o.kind   = TK_HEX;
      tok_o.nibble = 4'(ch_i[2:0] + 3'd1) + 4'd8;
    end
  end

endmodule

@@ sv/uuidp_fifo.sv @@
module uuidp_fifo
  import uuidp_pkg::*;
#(
  parameter int unsigned Depth = QDepthDefault
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       wr_i,
  input  tok_t                       wr_tok_i,
  input  logic                       rd_i,
  output tok_t                       rd_tok_o,
  output logic                       full_o,
  output logic                       empty_o,
  output logic [$clog2(Depth+1)-1:0] count_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  tok_t            mem_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;

  function automatic logic [PtrW-1:0] wrap_inc(logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign full_o   = (cnt_q == CntW'(Depth));
  assign empty_o  = (cnt_q == '0);
  assign count_o  = cnt_q;
  assign rd_tok_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wptr_q] <= wr_tok_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (wr_i) wptr_q <= wrap_inc(wptr_q);
      if (rd_i) rptr_q <= wrap_inc(rptr_q);
      if (wr_i && !rd_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (rd_i && !wr_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

@@ sv/uuidp_back.sv @@
module uuidp_back
  import uuidp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             tok_valid_i,
  input  tok_t             tok_i,
  output logic             tok_take_o,
  output logic             res_load_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic             status_o,
  output logic [HalfW-1:0] uuid_high_o,
  output logic [HalfW-1:0] uuid_low_o
);

  typedef enum logic [4:0] {
    PH_START  = 5'b00001,
    PH_BODY   = 5'b00010,
    PH_AFTER  = 5'b00100,
    PH_CLOSED = 5'b01000,
    PH_ERROR  = 5'b10000
  } phase_e;

  phase_e              phase_q, phase_d;
  logic [IdxW-1:0]     idx_q, idx_d;
  logic [2*HalfW-1:0]  acc_q, acc_d;
  logic                res_valid_q;
  logic                res_status_q;
  logic [2*HalfW-1:0]  res_val_q;
  logic                slot_free, is_nul, at_dash, body_ok;

  // A NUL needs a free result slot; every other token goes straight through
  assign slot_free  = !res_valid_q || pop_i;
  assign is_nul     = (tok_i.kind == TK_NUL);
  assign tok_take_o = tok_valid_i && (!is_nul || slot_free);
  assign res_load_o = tok_take_o && is_nul;

  assign at_dash = (idx_q == DashPos0) || (idx_q == DashPos1) ||
                   (idx_q == DashPos2) || (idx_q == DashPos3);
  assign body_ok = at_dash ? (tok_i.kind == TK_DASH) : (tok_i.kind == TK_HEX);

  always_comb begin
    phase_d = phase_q;
    idx_d   = idx_q;
    acc_d   = acc_q;
    if (tok_take_o) begin
      if (is_nul) begin
        phase_d = PH_START;
        idx_d   = '0;
        acc_d   = '0;
      end else begin
        case (phase_q)
          PH_START, PH_BODY: begin
            if (phase_q == PH_START && tok_i.kind == TK_LBRACE) begin
              phase_d = PH_BODY;
            end else if (!body_ok) begin
              phase_d = PH_ERROR;
            end else begin
              if (!at_dash) acc_d = {acc_q[2*HalfW-5:0], tok_i.nibble};
              idx_d   = idx_q + IdxW'(1);
              phase_d = (idx_q >= BodyLast) ? PH_AFTER : PH_BODY;
            end
          end
          PH_AFTER: begin
            phase_d = (tok_i.kind == TK_RBRACE) ? PH_CLOSED : PH_ERROR;
          end
          default: begin
            phase_d = PH_ERROR;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_START;
      idx_q       <= '0;
      acc_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      acc_q   <= acc_d;
      if (res_load_o) begin
        res_valid_q <= 1'b1;
      end else if (pop_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // Result slot payload; zero value on any failed parse
  always_ff @(posedge clk_i) begin
    if (res_load_o) begin
      if (phase_q == PH_AFTER || phase_q == PH_CLOSED) begin
        res_status_q <= 1'b0;
        res_val_q    <= acc_q;
      end else begin
        res_status_q <= 1'b1;
        res_val_q    <= '0;
      end
    end
  end

  assign empty_o     = !res_valid_q;
  assign status_o    = res_status_q;
  assign uuid_high_o = res_val_q[2*HalfW-1:HalfW];
  assign uuid_low_o  = res_val_q[HalfW-1:0];

endmodule

@@ sv/uuid_text_parser_unit.sv @@
// UUID text parser. Feed a text UUID one character per transfer on ch_i and
// end each string with a NUL (0). The accepted form is an optional leading
// '{', 32 hex digits in either case grouped 8-4-4-4-12 with '-' between the
// groups, an optional '}', then the NUL. Each NUL yields exactly one result:
// status_o 0 with the 128-bit value split over uuid_high_o (bytes 1..8, first
// byte most significant) and uuid_low_o (bytes 9..16), or status_o 1 with both
// halves zero; any other character yields nothing. After an error, characters
// are swallowed until the NUL. Throughput is one character per cycle: a
// character is classified as it enters, waits in a QDepth-entry token queue,
// and the parse engine retires one token per cycle. Only a NUL can stall the
// engine, and only while the single result slot is held and not popped.
// A NUL is written into the token queue, then loaded into the result slot,
// which drives empty low. Reset puts the parser at the start of a string.
module uuid_text_parser_unit
  import uuidp_pkg::*;
#(
  parameter int unsigned QDepth = QDepthDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  output logic             full,
  input  logic [7:0]       ch_i,
  output logic             empty,
  input  logic             pop,
  output logic             status_o,
  output logic [HalfW-1:0] uuid_high_o,
  output logic [HalfW-1:0] uuid_low_o
);

  tok_t                        in_tok, q_tok;
  logic                        q_full, q_empty, q_rd, q_wr, res_load;
  logic [$clog2(QDepth+1)-1:0] q_count;

  // Front: classify the character as it is transferred in
  uuidp_front u_front (
    .ch_i  (ch_i),
    .tok_o (in_tok)
  );

  assign full = q_full;
  assign q_wr = push && !q_full;

  // Token queue decouples the input stream from the parse engine
  uuidp_fifo #(
    .Depth (QDepth)
  ) u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (q_wr),
    .wr_tok_i (in_tok),
    .rd_i     (q_rd),
    .rd_tok_o (q_tok),
    .full_o   (q_full),
    .empty_o  (q_empty),
    .count_o  (q_count)
  );

  // Back: walk the grammar, shift in digits, hold the result slot
  uuidp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_valid_i (!q_empty),
    .tok_i       (q_tok),
    .tok_take_o  (q_rd),
    .res_load_o  (res_load),
    .pop_i       (pop),
    .empty_o     (empty),
    .status_o    (status_o),
    .uuid_high_o (uuid_high_o),
    .uuid_low_o  (uuid_low_o)
  );

  // A failed parse never shows a value
  a_err_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && status_o |-> (uuid_high_o == '0) && (uuid_low_o == '0))
    else $error("error result carries a nonzero value");

  // Never overwrite a result that has not been transferred out
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |-> empty || pop)
    else $error("result slot overwritten");

  // A pop with no new result loaded leaves the slot empty
  a_pop_drains : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && !empty && !res_load |=> empty)
    else $error("result slot not released after pop");

  // Queue occupancy stays within its depth
  a_q_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_count <= ($clog2(QDepth+1))'(QDepth))
    else $error("token queue overflow");

endmodule

@@ dv/tb_uuid_text_parser_unit.sv @@
`timescale 1ns / 1ps

module tb_uuid_text_parser_unit
  import uuidp_pkg::*;
;

  // Give up after this many cycles in which neither side completes a transfer.
  localparam int StallLimit = 4000;
  // Cycles to keep watching after the last expected result has arrived.
  localparam int DrainCycles = 16;

  typedef logic [7:0] text_q_t[$];

  typedef enum logic [2:0] {
    PH_START  = 3'd0,
    PH_BODY   = 3'd1,
    PH_AFTER  = 3'd2,
    PH_CLOSED = 3'd3,
    PH_ERROR  = 3'd4
  } parse_phase_e;

  typedef struct packed {
    logic             status;
    logic [HalfW-1:0] hi;
    logic [HalfW-1:0] lo;
  } uuid_result_t;

  logic             clk_i  = 1'b0;
  logic             rst_ni = 1'b0;
  logic             push   = 1'b0;
  logic [7:0]       ch_i   = 8'h00;
  logic             pop    = 1'b0;
  logic             full;
  logic             empty;
  logic             status_o;
  logic [HalfW-1:0] uuid_high_o;
  logic [HalfW-1:0] uuid_low_o;

  // Idle rates in percent; the main sequence changes them between phases.
  int send_idle_pct = 20;
  int recv_idle_pct = 87;
  int err_cnt       = 0;
  int stall_cycles  = 0;

  // Parser state as predicted from the transferred characters.
  parse_phase_e    phase_q;
  logic [IdxW-1:0] body_cnt;
  logic [127:0]    digits_acc;
  uuid_result_t    parsed_q[$];

  uuid_text_parser_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .ch_i       (ch_i),
    .empty      (empty),
    .pop        (pop),
    .status_o   (status_o),
    .uuid_high_o(uuid_high_o),
    .uuid_low_o (uuid_low_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic void clear_parse();
    phase_q    = PH_START;
    body_cnt   = '0;
    digits_acc = '0;
  endfunction

  // Decode one hex digit; bit 4 flags a valid digit.
  function automatic logic [4:0] decode_hex(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return {1'b1, 4'(c - 8'h30)};
    if (c >= 8'h61 && c <= 8'h66) return {1'b1, 4'(c - 8'h61 + 8'd10)};
    if (c >= 8'h41 && c <= 8'h46) return {1'b1, 4'(c - 8'h41 + 8'd10)};
    return 5'h00;
  endfunction

  function automatic void take_body(input logic [7:0] c);
    logic [4:0] nib;
    nib = decode_hex(c);
    if (body_cnt == DashPos0 || body_cnt == DashPos1 ||
        body_cnt == DashPos2 || body_cnt == DashPos3) begin
      if (c != ChDash) begin
        phase_q = PH_ERROR;
        return;
      end
    end else begin
      if (!nib[4]) begin
        phase_q = PH_ERROR;
        return;
      end
      digits_acc = {digits_acc[123:0], nib[3:0]};
    end
    body_cnt = body_cnt + 1'b1;
    phase_q  = (body_cnt >= BodyLen) ? PH_AFTER : PH_BODY;
  endfunction

  // Advance the prediction by one transferred character; a NUL queues a result.
  function automatic void track_char(input logic [7:0] c);
    uuid_result_t r;
    if (c == ChNul) begin
      if (phase_q == PH_AFTER || phase_q == PH_CLOSED) begin
        r = '{1'b0, digits_acc[127:64], digits_acc[63:0]};
      end else begin
        r = '{1'b1, '0, '0};
      end
      parsed_q.push_back(r);
      clear_parse();
      return;
    end
    case (phase_q)
      PH_START: begin
        if (c == ChLBrace) begin
          phase_q  = PH_BODY;
          body_cnt = '0;
        end else begin
          take_body(c);
        end
      end
      PH_BODY:  take_body(c);
      PH_AFTER: phase_q = (c == ChRBrace) ? PH_CLOSED : PH_ERROR;
      default:  phase_q = PH_ERROR;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Text builders
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return (upper ? 8'h41 : 8'h61) + 8'(n - 4'd10);
  endfunction

  // case_mode: 0 lower, 1 upper, 2 mixed at random per digit.
  function automatic text_q_t uuid_text(input logic [127:0] v, input bit open_b,
                                        input bit close_b, input int case_mode);
    text_q_t s;
    if (open_b) s.push_back(ChLBrace);
    for (int i = 0; i < 32; i++) begin
      if (i == 8 || i == 12 || i == 16 || i == 20) s.push_back(ChDash);
      s.push_back(hex_char(v[127 - 4 * i -: 4],
                           case_mode == 1 || (case_mode == 2 && $urandom_range(1) == 1)));
    end
    if (close_b) s.push_back(ChRBrace);
    return s;
  endfunction

  // Favor characters that sit next to a decision: delimiters and hex range edges.
  function automatic logic [7:0] odd_char();
    logic [7:0] picks[12];
    picks = '{ChDash, ChLBrace, ChRBrace, 8'h2F, 8'h3A, 8'h40, 8'h47, 8'h60,
               8'h67, 8'h39, 8'h46, 8'h66};
    if ($urandom_range(1) == 1) return picks[$urandom_range(11)];
    return 8'($urandom_range(255, 1));
  endfunction

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------

  // Transfer one character; call and return just after a falling edge.
  task automatic send_char(input logic [7:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push <= 1'b1;
    ch_i <= c;
    do @(posedge clk_i); while (full);
    track_char(c);
    @(negedge clk_i);
  endtask

  // Transfer a string and its terminating NUL.
  task automatic send_string(input text_q_t s);
    foreach (s[i]) send_char(s[i]);
    send_char(ChNul);
  endtask

  // Randomize pop every cycle at the configured rate.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    uuid_result_t want;
    if (rst_ni && pop && !empty) begin
      if (parsed_q.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected result status=%0b high=%h low=%h",
                 $time, status_o, uuid_high_o, uuid_low_o);
      end else begin
        want = parsed_q.pop_front();
        if (status_o !== want.status) begin
          err_cnt++;
          $display("%0t: status expected %0b actual %0b", $time, want.status, status_o);
        end
        if (uuid_high_o !== want.hi) begin
          err_cnt++;
          $display("%0t: uuid_high expected %h actual %h", $time, want.hi, uuid_high_o);
        end
        if (uuid_low_o !== want.lo) begin
          err_cnt++;
          $display("%0t: uuid_low expected %h actual %h", $time, want.lo, uuid_low_o);
        end
      end
    end
  end

  // Watchdog: count cycles without any transfer on either side.
  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= StallLimit) begin
      $display("%0t: no transfer for %0d cycles", $time, stall_cycles);
      $display("[uuid_text_parser_unit] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Well-formed text with every brace combination and the value extremes.
  task automatic test_brace_forms();
    send_string(uuid_text('0, 1'b1, 1'b1, 0));
    send_string(uuid_text('1, 1'b0, 1'b0, 1));
    send_string(uuid_text('1, 1'b0, 1'b1, 0));
    send_string(uuid_text(128'h0123456789abcdeffedcba9876543210, 1'b1, 1'b0, 2));
  endtask

  // Strings that end early, and single characters at the edges of the hex ranges.
  task automatic test_short_strings();
    text_q_t s;
    logic [7:0] edges[6];
    edges = '{8'h2F, 8'h3A, 8'h40, 8'h47, 8'h60, 8'h67};
    s = {};
    send_string(s);
    s = {ChLBrace};
    send_string(s);
    s = {ChLBrace, ChRBrace};
    send_string(s);
    s = uuid_text(128'hA5A5_5A5A_0F0F_F0F0_1234_5678_9ABC_DEF0, 1'b0, 1'b0, 1);
    s = s[0:34];
    send_string(s);
    foreach (edges[i]) begin
      s = {edges[i]};
      send_string(s);
    end
  endtask

  // Misplaced delimiters and trailing junk; characters after an error are swallowed.
  task automatic test_malformed();
    text_q_t base;
    text_q_t s;
    base = uuid_text(128'hDEADBEEF_CAFE_F00D_8BAD_0123456789AB, 1'b0, 1'b0, 2);
    s = base; s[5] = ChLBrace;             send_string(s);
    s = base; s[3] = ChDash;               send_string(s);
    s = base; s[8] = 8'h30;                send_string(s);
    s = base; s.push_back(8'h30);          send_string(s);
    s = base; s.push_back(ChRBrace); s.push_back(ChRBrace); send_string(s);
    s = base; s.push_back(ChRBrace); s.push_back(8'h61);    send_string(s);
    s = base; s[20] = 8'hFF;               send_string(s);
    s = base; s.push_front(ChLBrace); s.push_front(ChLBrace); send_string(s);
  endtask

  // Mostly well-formed strings with random content; the rest is broken or noise.
  task automatic test_random(input int char_budget);
    text_q_t s;
    int      sent;
    int      kind;
    int      pos;
    int      len;
    sent = 0;
    while (sent < char_budget) begin
      kind = $urandom_range(99);
      s = uuid_text({$urandom(), $urandom(), $urandom(), $urandom()},
                    $urandom_range(1) == 1, $urandom_range(1) == 1, $urandom_range(2));
      if (kind >= 65 && kind < 75) begin
        // Corrupt one character.
        pos = $urandom_range(s.size() - 1);
        s[pos] = odd_char();
      end else if (kind >= 75 && kind < 83) begin
        // Cut the string short.
        len = $urandom_range(s.size() - 1);
        while (s.size() > len) void'(s.pop_back());
      end else if (kind >= 83 && kind < 90) begin
        // Insert a stray character.
        pos = $urandom_range(s.size());
        s.insert(pos, odd_char());
      end else if (kind >= 90) begin
        // Plain noise.
        s = {};
        len = $urandom_range(40);
        repeat (len) s.push_back(odd_char());
      end
      send_string(s);
      sent += s.size() + 1;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    clear_parse();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Slow receiver first.
    send_idle_pct = 20;
    recv_idle_pct = 87;
    test_brace_forms();
    test_short_strings();
    test_malformed();
    test_random(460);

    // Slow sender next, then full rate on both sides.
    send_idle_pct = 87;
    recv_idle_pct = 20;
    test_random(460);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(460);

    push <= 1'b0;
    while (parsed_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("[uuid_text_parser_unit] OK");
    end else begin
      $display("[uuid_text_parser_unit] ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/uuidp_pkg.sv
sv/uuidp_front.sv
sv/uuidp_fifo.sv
sv/uuidp_back.sv
sv/uuid_text_parser_unit.sv
dv/tb_uuid_text_parser_unit.sv
